FILE: rtl/core/swe_pkg.sv
// Shared types and constants for the software volume envelope.
// Holds the phase, opcode and register codes and the structs passed between the blocks.
// Depends on nothing.
`timescale 1ns / 1ps

package swe_pkg;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_KEY_ON,
    OP_KEY_OFF,
    OP_NONE
  } op_t;

  localparam logic [1:0] OPC_TICK    = 2'd0;
  localparam logic [1:0] OPC_KEY_ON  = 2'd1;
  localparam logic [1:0] OPC_KEY_OFF = 2'd2;
  localparam logic [1:0] OPC_NONE    = 2'd3;

  typedef enum logic [2:0] {
    REG_EXTENDED_MODE = 3'd0,
    REG_TIMER_SYNC    = 3'd1,
    REG_ATTACK_PARAM  = 3'd2,
    REG_DECAY_PARAM   = 3'd3,
    REG_SUSTAIN_PARAM = 3'd4,
    REG_RELEASE_PARAM = 3'd5,
    REG_SUSTAIN_LEVEL = 3'd6
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic signed [4:0] LEVEL_MAX = 5'sd15;
  localparam logic signed [4:0] LEVEL_MIN = -5'sd15;

  typedef struct packed {
    logic              extended_mode;
    logic              timer_sync;
    logic [7:0]        attack_param;
    logic signed [5:0] decay_param;
    logic [7:0]        sustain_param;
    logic [7:0]        release_param;
    logic [3:0]        sustain_level;
  } cfg_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] steps;
  } cmd_t;

  typedef struct packed {
    logic signed [4:0] level;
    logic              changed;
    phase_t            phase;
  } result_t;

endpackage

FILE: rtl/core/software_volume_envelope_top.sv
// Top level of the software volume envelope: register file, event front end and step engine.
// Depends on swe_pkg, swe_cfg, swe_front and swe_back.
//
//   channel   ports                                   transfer when
//   input     push, full, in_opcode, in_elapsed_ticks  push && !full
//   result    pop, empty, out_level/changed/phase      pop && !empty
//   config    psel, penable, pwrite, paddr, pwdata     psel && penable && pwrite && pready
//
// Key on, key off and unused events run no envelope step in the step engine. A tick runs
// one envelope step, or elapsed_ticks steps with timer sync set (a tick of zero steps still
// yields a result), so the step engine sets the rate. The command queue registers each command.
// Reset is synchronous and clears the envelope state and both queues at once.
// full rises with two commands queued; the step engine waits while two results are unread.
`timescale 1ns / 1ps

module software_volume_envelope_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 in_opcode,
  input  logic [7:0]                 in_elapsed_ticks,
  input  logic                       pop,
  output logic                       empty,
  output logic signed [4:0]          out_level,
  output logic                       out_changed,
  output logic [2:0]                 out_phase,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [swe_pkg::ADDR_W-1:0] paddr,
  input  logic [swe_pkg::DATA_W-1:0] pwdata,
  output logic [swe_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  swe_pkg::cfg_t cfg;
  swe_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  swe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  swe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_opcode        (in_opcode),
    .in_elapsed_ticks (in_elapsed_ticks),
    .timer_sync       (cfg.timer_sync),
    .cmd_valid        (cmd_valid),
    .cmd              (cmd),
    .cmd_pop          (cmd_pop)
  );

  swe_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .out_level   (out_level),
    .out_changed (out_changed),
    .out_phase   (out_phase)
  );

endmodule

FILE: rtl/core/swe_cfg.sv
// Configuration register file of the software volume envelope on an APB-style port.
// Depends on swe_pkg for the register codes and the cfg_t struct.
`timescale 1ns / 1ps

module swe_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [swe_pkg::ADDR_W-1:0]  paddr,
  input  logic [swe_pkg::DATA_W-1:0]  pwdata,
  output logic [swe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output swe_pkg::cfg_t               cfg
);

  swe_pkg::cfg_t     cfg_r;
  swe_pkg::cfg_t     cfg_nxt;
  swe_pkg::reg_idx_t idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign cfg    = cfg_r;
  assign idx    = swe_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        swe_pkg::REG_EXTENDED_MODE: cfg_nxt.extended_mode = pwdata[0];
        swe_pkg::REG_TIMER_SYNC:    cfg_nxt.timer_sync    = pwdata[0];
        swe_pkg::REG_ATTACK_PARAM:  cfg_nxt.attack_param  = pwdata[7:0];
        swe_pkg::REG_DECAY_PARAM:   cfg_nxt.decay_param   = $signed(pwdata[5:0]);
        swe_pkg::REG_SUSTAIN_PARAM: cfg_nxt.sustain_param = pwdata[7:0];
        swe_pkg::REG_RELEASE_PARAM: cfg_nxt.release_param = pwdata[7:0];
        swe_pkg::REG_SUSTAIN_LEVEL: cfg_nxt.sustain_level = pwdata[3:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      swe_pkg::REG_EXTENDED_MODE: prdata[0]   = cfg_r.extended_mode;
      swe_pkg::REG_TIMER_SYNC:    prdata[0]   = cfg_r.timer_sync;
      swe_pkg::REG_ATTACK_PARAM:  prdata[7:0] = cfg_r.attack_param;
      swe_pkg::REG_DECAY_PARAM:   prdata[5:0] = cfg_r.decay_param;
      swe_pkg::REG_SUSTAIN_PARAM: prdata[7:0] = cfg_r.sustain_param;
      swe_pkg::REG_RELEASE_PARAM: prdata[7:0] = cfg_r.release_param;
      swe_pkg::REG_SUSTAIN_LEVEL: prdata[3:0] = cfg_r.sustain_level;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/swe_front.sv
// Front end of the software volume envelope: accepts events, classifies them into commands
// and holds them in a short command queue. Depends on swe_pkg.
`timescale 1ns / 1ps

module swe_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  output logic          full,
  input  logic [1:0]    in_opcode,
  input  logic [7:0]    in_elapsed_ticks,
  input  logic          timer_sync,
  output logic          cmd_valid,
  output swe_pkg::cmd_t cmd,
  input  logic          cmd_pop
);

  localparam int unsigned CW = swe_pkg::QCNT_W;
  localparam int unsigned PW = swe_pkg::QPTR_W;

  swe_pkg::cmd_t   mem_r [swe_pkg::QDEPTH];
  swe_pkg::cmd_t   cmd_in;
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            wr_en;
  logic            rd_en;

  always_comb begin
    unique case (in_opcode)
      swe_pkg::OPC_TICK:    cmd_in.op = swe_pkg::OP_TICK;
      swe_pkg::OPC_KEY_ON:  cmd_in.op = swe_pkg::OP_KEY_ON;
      swe_pkg::OPC_KEY_OFF: cmd_in.op = swe_pkg::OP_KEY_OFF;
      swe_pkg::OPC_NONE:    cmd_in.op = swe_pkg::OP_NONE;
      default:              cmd_in.op = swe_pkg::OP_NONE;
    endcase
    cmd_in.steps = timer_sync ? in_elapsed_ticks : 8'd1;
  end

  assign full      = (cnt_r == CW'(swe_pkg::QDEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = mem_r[rd_ptr_r];
  assign wr_en     = push && !full;
  assign rd_en     = cmd_pop && cmd_valid;

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

FILE: rtl/core/swe_back.sv
// Back end of the software volume envelope: the envelope state, a one-step-per-cycle
// step engine and the result queue. Depends on swe_pkg.
`timescale 1ns / 1ps

module swe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  swe_pkg::cfg_t     cfg,
  input  logic              cmd_valid,
  input  swe_pkg::cmd_t     cmd,
  output logic              cmd_pop,
  input  logic              pop,
  output logic              empty,
  output logic signed [4:0] out_level,
  output logic              out_changed,
  output logic [2:0]        out_phase
);

  localparam int unsigned CW = swe_pkg::QCNT_W;
  localparam int unsigned PW = swe_pkg::QPTR_W;

  function automatic logic signed [8:0] reload_signed(input logic signed [5:0] p);
    logic signed [8:0] t;
    t = $signed({{3{p[5]}}, p}) - 9'sd16;
    return (p < 6'sd16) ? (t <<< 1) : t;
  endfunction

  function automatic logic signed [8:0] reload_unsigned(input logic [7:0] p);
    logic signed [8:0] t;
    t = $signed({1'b0, p}) - 9'sd16;
    return (p < 8'd16) ? (t <<< 1) : t;
  endfunction

  function automatic logic signed [8:0] reload_release(input logic [7:0] p);
    logic signed [9:0] t;
    t = $signed({1'b0, p, 1'b0}) - 10'sd16;
    return (t > 10'sd255) ? 9'sd255 : t[8:0];
  endfunction

  function automatic logic signed [4:0] clamp_depth(input logic signed [5:0] p);
    logic signed [4:0] r;
    if (p > 6'sd15) begin
      r = swe_pkg::LEVEL_MAX;
    end else if (p < -6'sd15) begin
      r = swe_pkg::LEVEL_MIN;
    end else begin
      r = p[4:0];
    end
    return r;
  endfunction

  swe_pkg::phase_t   phase_r, phase_nxt, st_phase;
  logic signed [4:0] level_r, level_nxt, st_level;
  logic signed [8:0] ac_r, ac_nxt, st_ac;
  logic signed [8:0] dc_r, dc_nxt, st_dc;
  logic signed [8:0] sc_r, sc_nxt, st_sc;
  logic signed [8:0] rc_r, rc_nxt, st_rc;
  logic              busy_r, busy_nxt;
  logic [7:0]        steps_r, steps_nxt;
  logic              chg_r, chg_nxt;
  logic signed [9:0] lvl10;
  logic signed [9:0] sum;
  logic signed [4:0] lvl_dec;
  logic              step_chg;
  logic              start;
  logic              emit;
  swe_pkg::result_t  res_in;

  swe_pkg::result_t  mem_r [swe_pkg::QDEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              rd_en;

  assign lvl10   = $signed({{5{level_r[4]}}, level_r});
  assign lvl_dec = (level_r == swe_pkg::LEVEL_MIN) ? swe_pkg::LEVEL_MIN : level_r - 5'sd1;

  always_comb begin
    st_phase = phase_r;
    st_level = level_r;
    st_ac    = ac_r;
    st_dc    = dc_r;
    st_sc    = sc_r;
    st_rc    = rc_r;
    sum      = '0;
    if (cfg.extended_mode) begin
      unique case (phase_r)
        swe_pkg::PH_OFF: begin
          st_phase = phase_r;
        end
        swe_pkg::PH_ATTACK: begin
          if (ac_r > 9'sd0) begin
            sum = lvl10 + $signed({ac_r[8], ac_r});
            if (sum < 10'sd15) begin
              st_level = $signed(sum[4:0]);
              st_ac    = $signed({1'b0, cfg.attack_param}) - 9'sd16;
            end else begin
              st_level = swe_pkg::LEVEL_MAX;
              st_phase = (cfg.sustain_level == 4'd15) ? swe_pkg::PH_SUSTAIN
                                                      : swe_pkg::PH_DECAY;
            end
          end else if (cfg.attack_param != 8'd0) begin
            st_ac = ac_r + 9'sd1;
          end
        end
        swe_pkg::PH_DECAY: begin
          if (dc_r > 9'sd0) begin
            sum = lvl10 - $signed({dc_r[8], dc_r});
            if (sum < $signed({6'b0, cfg.sustain_level})) begin
              st_level = $signed({1'b0, cfg.sustain_level});
              st_phase = swe_pkg::PH_SUSTAIN;
            end else begin
              st_level = $signed(sum[4:0]);
              st_dc    = reload_signed(cfg.decay_param);
            end
          end else if (cfg.decay_param != 6'sd0) begin
            st_dc = dc_r + 9'sd1;
          end
        end
        swe_pkg::PH_SUSTAIN: begin
          if (sc_r > 9'sd0) begin
            sum      = lvl10 - $signed({sc_r[8], sc_r});
            st_level = (sum < 10'sd0) ? 5'sd0 : $signed(sum[4:0]);
            st_sc    = reload_unsigned(cfg.sustain_param);
          end else if (cfg.sustain_param != 8'd0) begin
            st_sc = sc_r + 9'sd1;
          end
        end
        swe_pkg::PH_RELEASE: begin
          if (rc_r > 9'sd0) begin
            sum      = lvl10 - $signed({rc_r[8], rc_r});
            st_level = (sum < 10'sd0) ? 5'sd0 : $signed(sum[4:0]);
            st_rc    = reload_release(cfg.release_param);
          end else if (cfg.release_param != 8'd0) begin
            st_rc = rc_r + 9'sd1;
          end
        end
        default: begin
          st_phase = phase_r;
        end
      endcase
    end else begin
      unique case (phase_r)
        swe_pkg::PH_OFF: begin
          st_phase = phase_r;
        end
        swe_pkg::PH_ATTACK: begin
          st_ac = ac_r - 9'sd1;
          if (st_ac == 9'sd0) begin
            st_phase = swe_pkg::PH_DECAY;
            st_level = clamp_depth(cfg.decay_param);
          end
        end
        swe_pkg::PH_DECAY, swe_pkg::PH_SUSTAIN: begin
          if (sc_r != 9'sd0) begin
            st_sc = sc_r - 9'sd1;
            if (st_sc == 9'sd0) begin
              st_sc    = $signed({1'b0, cfg.sustain_param});
              st_level = lvl_dec;
            end
          end
        end
        swe_pkg::PH_RELEASE: begin
          if (rc_r == 9'sd0) begin
            st_level = swe_pkg::LEVEL_MIN;
          end else begin
            st_rc = rc_r - 9'sd1;
            if (st_rc == 9'sd0) begin
              st_rc    = $signed({1'b0, cfg.release_param});
              st_level = lvl_dec;
            end
          end
        end
        default: begin
          st_phase = phase_r;
        end
      endcase
    end
    step_chg = (st_level != level_r);
  end

  assign start   = !busy_r && cmd_valid && (cnt_r != CW'(swe_pkg::QDEPTH));
  assign cmd_pop = start;

  always_comb begin
    phase_nxt      = phase_r;
    level_nxt      = level_r;
    ac_nxt         = ac_r;
    dc_nxt         = dc_r;
    sc_nxt         = sc_r;
    rc_nxt         = rc_r;
    busy_nxt       = busy_r;
    steps_nxt      = steps_r;
    chg_nxt        = chg_r;
    emit           = 1'b0;
    res_in.level   = level_r;
    res_in.changed = 1'b0;
    res_in.phase   = phase_r;
    if (busy_r) begin
      phase_nxt = st_phase;
      level_nxt = st_level;
      ac_nxt    = st_ac;
      dc_nxt    = st_dc;
      sc_nxt    = st_sc;
      rc_nxt    = st_rc;
      chg_nxt   = chg_r || step_chg;
      if (steps_r == 8'd1) begin
        busy_nxt       = 1'b0;
        emit           = 1'b1;
        res_in.level   = st_level;
        res_in.changed = chg_r || step_chg;
        res_in.phase   = st_phase;
      end else begin
        steps_nxt = steps_r - 8'd1;
      end
    end else if (start) begin
      emit = 1'b1;
      unique case (cmd.op)
        swe_pkg::OP_TICK: begin
          if (cmd.steps != 8'd0) begin
            phase_nxt      = st_phase;
            level_nxt      = st_level;
            ac_nxt         = st_ac;
            dc_nxt         = st_dc;
            sc_nxt         = st_sc;
            rc_nxt         = st_rc;
            res_in.level   = st_level;
            res_in.changed = step_chg;
            res_in.phase   = st_phase;
            if (cmd.steps != 8'd1) begin
              emit      = 1'b0;
              busy_nxt  = 1'b1;
              steps_nxt = cmd.steps - 8'd1;
              chg_nxt   = step_chg;
            end
          end
        end
        swe_pkg::OP_KEY_ON: begin
          phase_nxt = swe_pkg::PH_ATTACK;
          level_nxt = 5'sd0;
          if (cfg.extended_mode) begin
            ac_nxt = $signed({1'b0, cfg.attack_param}) - 9'sd16;
            dc_nxt = reload_signed(cfg.decay_param);
            sc_nxt = reload_unsigned(cfg.sustain_param);
            rc_nxt = reload_release(cfg.release_param);
          end else begin
            ac_nxt = $signed({1'b0, cfg.attack_param});
            sc_nxt = $signed({1'b0, cfg.sustain_param});
            rc_nxt = $signed({1'b0, cfg.release_param});
            if (cfg.attack_param == 8'd0) begin
              phase_nxt = swe_pkg::PH_DECAY;
              level_nxt = clamp_depth(cfg.decay_param);
            end
          end
          res_in.level   = level_nxt;
          res_in.changed = (level_nxt != level_r);
          res_in.phase   = phase_nxt;
        end
        swe_pkg::OP_KEY_OFF: begin
          if (phase_r != swe_pkg::PH_OFF) begin
            phase_nxt = swe_pkg::PH_RELEASE;
          end
          res_in.phase = phase_nxt;
        end
        swe_pkg::OP_NONE: begin
          res_in.phase = phase_r;
        end
        default: begin
          res_in.phase = phase_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= swe_pkg::PH_OFF;
      level_r <= '0;
      ac_r    <= '0;
      dc_r    <= '0;
      sc_r    <= '0;
      rc_r    <= '0;
      busy_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      level_r <= level_nxt;
      ac_r    <= ac_nxt;
      dc_r    <= dc_nxt;
      sc_r    <= sc_nxt;
      rc_r    <= rc_nxt;
      busy_r  <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r <= steps_nxt;
    chg_r   <= chg_nxt;
  end

  assign empty       = (cnt_r == '0);
  assign rd_en       = pop && !empty;
  assign out_level   = mem_r[rd_ptr_r].level;
  assign out_changed = mem_r[rd_ptr_r].changed;
  assign out_phase   = mem_r[rd_ptr_r].phase;

  always_comb begin
    wr_ptr_nxt = emit ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + CW'(emit) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      mem_r[wr_ptr_r] <= res_in;
    end
  end

endmodule

FILE: rtl/core/swe_checker.sv
// Port-level checks for the software volume envelope, bound to the top level.
// Depends on swe_pkg and software_volume_envelope_top.
`timescale 1ns / 1ps

module swe_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              pop,
  input logic              empty,
  input logic signed [4:0] out_level,
  input logic              out_changed,
  input logic [2:0]        out_phase
);

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_level != 5'b10000)
    else $error("result level outside -15..15");

  a_off_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_phase == swe_pkg::PH_OFF) |-> (out_level == 5'sd0 && !out_changed))
    else $error("envelope off but level nonzero or changed");

  a_attack_below_top: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_phase == swe_pkg::PH_ATTACK) |-> out_level != swe_pkg::LEVEL_MAX)
    else $error("attack phase reported at full level");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_level) && $stable(out_changed)
                          && $stable(out_phase)))
    else $error("waiting result changed before its transfer");

endmodule

bind software_volume_envelope_top swe_checker u_swe_checker (.*);
